@@ hw/rtl/pud_pkg.sv @@
// ----------------------------------------------------------------------------
// pud_pkg
// Shared types, character codes and helpers for the percent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pud_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int unsigned MAX_RES   = 3;
    localparam int unsigned Q_DEPTH   = 8;
    localparam int unsigned Q_AW      = $clog2(Q_DEPTH);
    // room kept free so a staged item and a newly taken one both fit
    localparam int unsigned Q_ACCEPT_MAX = Q_DEPTH - 2 * MAX_RES;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_PCT    = 2'd1,
        PH_DIGIT  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       str_end;
    } t_beat;

    typedef struct packed {
        logic [1:0]  cnt;
        t_beat [2:0] beat;
    } t_res_set;

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic [7:0] map_plus(input logic [7:0] c, input logic plus_mode);
        return (plus_mode && c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pud_decode.sv @@
// ----------------------------------------------------------------------------
// pud_decode
// Escape state machine: turns one staged input byte into up to three beats.
// ----------------------------------------------------------------------------
`default_nettype none

module pud_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    input  wire logic            i_plus_mode,
    output pud_pkg::t_res_set    o_res
);
    import pud_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic [4:0] hv_in;
    logic [4:0] hv_held;
    logic [7:0] mb;
    logic [7:0] d0, d1, d2;
    logic [1:0] cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_held  <= 8'd0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    always_comb begin
        hv_in   = hex_value(i_byte);
        hv_held = hex_value(r_held);
        mb      = map_plus(i_byte, i_plus_mode);
        n_phase = PH_NORMAL;
        n_held  = r_held;
        d0      = CH_PERCENT;
        d1      = mb;
        d2      = mb;
        cnt     = 2'd0;
        unique case (r_phase)
            PH_PCT: begin
                if (hv_in[4]) begin
                    n_held = i_byte;
                    if (i_last) begin
                        // escape cut short: flush '%' and the digit
                        d1  = i_byte;
                        cnt = 2'd2;
                    end else begin
                        n_phase = PH_DIGIT;
                    end
                end else begin
                    cnt = 2'd2;
                end
            end
            PH_DIGIT: begin
                if (hv_in[4]) begin
                    d0  = {hv_held[3:0], hv_in[3:0]};
                    cnt = 2'd1;
                end else begin
                    d1  = r_held;
                    cnt = 2'd3;
                end
            end
            default: begin
                if (i_byte == CH_PERCENT) begin
                    if (i_last) begin
                        cnt = 2'd1;
                    end else begin
                        n_phase = PH_PCT;
                    end
                end else begin
                    d0  = mb;
                    cnt = 2'd1;
                end
            end
        endcase

        o_res.cnt = i_valid ? cnt : 2'd0;
        o_res.beat[0].data     = d0;
        o_res.beat[1].data     = d1;
        o_res.beat[2].data     = d2;
        o_res.beat[0].run_last = (cnt == 2'd1);
        o_res.beat[1].run_last = (cnt == 2'd2);
        o_res.beat[2].run_last = (cnt == 2'd3);
        o_res.beat[0].str_end  = i_last && (cnt == 2'd1);
        o_res.beat[1].str_end  = i_last && (cnt == 2'd2);
        o_res.beat[2].str_end  = i_last && (cnt == 2'd3);
    end

endmodule

`default_nettype wire

@@ hw/rtl/pud_fifo.sv @@
// ----------------------------------------------------------------------------
// pud_fifo
// Result queue: takes up to three beats a cycle, hands out one a cycle while the reader is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pud_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pud_pkg::t_res_set i_res,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output pud_pkg::t_beat         o_beat,
    output logic                   o_room
);
    import pud_pkg::*;

    t_beat           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]   r_count, n_count;
    logic            pop;

    always_comb begin
        pop      = (r_count != '0) && i_ready;
        n_wr_ptr = r_wr_ptr + Q_AW'(i_res.cnt);
        n_rd_ptr = r_rd_ptr + Q_AW'(pop);
        n_count  = r_count + (Q_AW+1)'(i_res.cnt) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (Q_AW'(i) < Q_AW'(i_res.cnt)) begin
                r_mem[r_wr_ptr + Q_AW'(i)] <= i_res.beat[i];
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= (Q_AW+1)'(Q_ACCEPT_MAX));

endmodule

`default_nettype wire

@@ hw/rtl/percent_url_decoder.sv @@
// ----------------------------------------------------------------------------
// percent_url_decoder
// Streaming URL percent decoder with optional '+' to space conversion.
// ----------------------------------------------------------------------------
// Path: an input beat is registered, decoded combinationally and queued.
// Throughput: one input beat per cycle while each yields at most one result
// and the master side is ready; the output side moves one beat per cycle
// while ready, so 2- and 3-beat escapes drain through the 8-entry result
// queue, which sets the input back-pressure.
// Reset: synchronous active-low clears escape state, queue and plus_mode.
`default_nettype none

module percent_url_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,    // plus_mode
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // in_last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // run_last
    output logic            m_axis_tuser    // [0] string_end
);
    import pud_pkg::*;

    logic       r_plus_mode;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_res_set   res;
    t_beat      head;
    logic       room;

    assign s_axis_tready = room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_mode <= 1'b0;
            r_in_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_plus_mode <= i_cfg_wdata;
            end
            r_in_valid <= s_axis_tvalid && room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && room) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    pud_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_plus_mode (r_plus_mode),
        .o_res       (res)
    );

    pud_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_beat  (head),
        .o_room  (room)
    );

    assign m_axis_tdata = head.data;
    assign m_axis_tlast = head.run_last;
    assign m_axis_tuser = head.str_end;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for percent_url_decoder. Encoded strings go in on the
// slave stream. A local decoder model predicts every output beat: byte,
// run_last and string end. Each beat taken on the master stream is checked
// against the oldest prediction. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
    import pud_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic       i_cfg_wdata   = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;   // in_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;           // run_last
    logic       m_axis_tuser;           // [0] string_end

    // decoder model state
    logic       plus_on    = 1'b0;
    t_phase     esc_phase  = PH_NORMAL;
    logic [7:0] held_char  = 8'h00;

    t_beat      decoded_q[$];
    int         err_count   = 0;
    bit         gaps_on     = 1'b0;
    int         stall_left  = 0;
    int         idle_cycles = 0;

    percent_url_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // -1 when c is not a hex digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] literal_char(input logic [7:0] c);
        if (plus_on && c == CH_PLUS) return CH_SPACE;
        return c;
    endfunction

    // advance the decoder model by one input byte, queue the beats it yields
    function automatic void decode_byte(input logic [7:0] b, input logic is_last);
        logic [7:0] outs [3];
        int         n;
        int         v;
        n = 0;
        v = hex_nibble(b);
        case (esc_phase)
            PH_PCT: begin
                if (v >= 0) begin
                    held_char = b;
                    esc_phase = PH_DIGIT;
                end else begin
                    outs[0] = CH_PERCENT;
                    outs[1] = literal_char(b);
                    n = 2;
                    esc_phase = PH_NORMAL;
                end
            end
            PH_DIGIT: begin
                // held_char is always a valid digit here
                if (v >= 0) begin
                    outs[0] = 8'(hex_nibble(held_char) * 16 + v);
                    n = 1;
                end else begin
                    outs[0] = CH_PERCENT;
                    outs[1] = held_char;
                    outs[2] = literal_char(b);
                    n = 3;
                end
                esc_phase = PH_NORMAL;
            end
            default: begin
                if (b == CH_PERCENT) begin
                    esc_phase = PH_PCT;
                end else begin
                    outs[0] = literal_char(b);
                    n = 1;
                end
            end
        endcase
        if (is_last) begin
            // flush a cut escape literally
            if (esc_phase == PH_PCT) begin
                outs[n] = CH_PERCENT;
                n = n + 1;
            end else if (esc_phase == PH_DIGIT) begin
                outs[n] = CH_PERCENT;
                outs[n + 1] = held_char;
                n = n + 2;
            end
            esc_phase = PH_NORMAL;
        end
        for (int i = 0; i < n; i++) begin
            decoded_q.push_back('{data: outs[i], run_last: (i == n - 1),
                                  str_end: (is_last && i == n - 1)});
        end
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int idx;
        idx = $urandom_range(0, 21);
        if (idx < 10) return 8'(int'("0") + idx);
        if (idx < 16) return 8'(int'("a") + idx - 10);
        return 8'(int'("A") + idx - 16);
    endfunction

    // output side: random stall bursts while gaps are enabled
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_beat exp_beat;
        if (m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual byte %h last %b end %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                err_count++;
            end else begin
                exp_beat = decoded_q.pop_front();
                if (m_axis_tdata !== exp_beat.data) begin
                    $display("%0t: out_byte mismatch, expected %h, actual %h",
                             $time, exp_beat.data, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== exp_beat.run_last) begin
                    $display("%0t: run_last mismatch, expected %b, actual %b",
                             $time, exp_beat.run_last, m_axis_tlast);
                    err_count++;
                end
                if (m_axis_tuser !== exp_beat.str_end) begin
                    $display("%0t: string_end mismatch, expected %b, actual %b",
                             $time, exp_beat.str_end, m_axis_tuser);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_byte(b, is_last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    // stop input, drain all results, let the pipeline settle, then write
    task automatic set_plus_mode(input logic mode);
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        plus_on = mode;
    endtask

    task automatic test_plain_escapes();
        gaps_on = 1'b1;
        set_plus_mode(1'b0);
        send_text("%4a%FF");
        send_text("%4G");
        send_text("%%");
        send_text("%+");    // '+' stays '+' with plus mode off
        send_text("%4");    // cut after one digit
        send_text("%");     // bare percent as last byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_plus_mode();
        set_plus_mode(1'b1);
        send_text("%+");
        send_text("%4+");
        send_text("+");
    endtask

    task automatic test_random(input logic mode, input int n_items, input bit idle_ok);
        logic [7:0] str_q[$];
        int         sent;
        int         len;
        int         r;
        set_plus_mode(mode);
        sent = 0;
        while (sent < n_items) begin
            str_q.delete();
            len = $urandom_range(1, 12);
            while (str_q.size() < len) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    str_q.push_back(CH_PERCENT);
                    str_q.push_back(rand_hex_char());
                    str_q.push_back(rand_hex_char());
                end else if (r < 50) begin
                    str_q.push_back(CH_PERCENT);
                    str_q.push_back(8'($urandom_range(0, 255)));
                end else if (r < 60) begin
                    str_q.push_back(CH_PERCENT);
                    str_q.push_back(rand_hex_char());
                    str_q.push_back(8'($urandom_range(0, 255)));
                end else if (r < 72) begin
                    str_q.push_back(CH_PLUS);
                end else if (r < 78) begin
                    str_q.push_back(CH_PERCENT);
                end else begin
                    str_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            // some strings run with no idling at all
            gaps_on = idle_ok && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < str_q.size(); i++) begin
                send_byte(str_q[i], i == str_q.size() - 1);
            end
            sent += str_q.size();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_escapes();
        test_plus_mode();
        test_random(1'b0, 90, 1'b1);
        test_random(1'b1, 90, 1'b1);
        test_random(1'b0, 90, 1'b1);
        test_random(1'b1, 100, 1'b0);
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && decoded_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
